### design/waveform_peak_envelope_top_defines.svh
// Assertion macros used by the waveform peak envelope top module.
`ifndef WAVEFORM_PEAK_ENVELOPE_TOP_DEFINES_SVH
`define WAVEFORM_PEAK_ENVELOPE_TOP_DEFINES_SVH

// Same-cycle implication, checked on aclk outside of reset.
`define WPE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("Same-cycle check failed.");

// Next-cycle implication, checked on aclk outside of reset.
`define WPE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("Next-cycle check failed.");

`endif

### design/wpe_pkg.sv
// Constants and codes for the waveform peak envelope decimator.
package wpe_pkg;

    localparam int SPP_BITS   = 21;
    localparam int CHUNK_BITS = 16;
    localparam int SCALE_BITS = 8;
    localparam int PEAK_BITS  = 8;
    localparam int NORM_BITS  = 16;
    localparam int CFG_BITS   = 21;
    localparam int NSLOT      = 3;

    localparam logic [SPP_BITS-1:0]   SPP_RESET   = 21'd64;
    localparam logic [CHUNK_BITS-1:0] CHUNK_RESET = 16'd10000;
    localparam logic [SCALE_BITS-1:0] SCALE_RESET = 8'd120;

    typedef enum logic [1:0] {
        CFG_SAMPLES_PER_POINT = 2'd0,
        CFG_CHUNK_SIZE        = 2'd1,
        CFG_PEAK_SCALE        = 2'd2
    } cfg_index_t;

    typedef enum logic {
        KIND_PAIR = 1'b0,
        KIND_NORM = 1'b1
    } kind_t;

    // Positions in the per-transaction result mask, in emission order.
    localparam int SLOT_PAIR  = 0;
    localparam int SLOT_NORM  = 1;
    localparam int SLOT_FLUSH = 2;

endpackage

### design/waveform_peak_envelope_top.sv
// Min/max peak envelope decimator with chunked max-abs tracking, single module.
//
// Each accepted sample transaction updates the running peaks and counters in the
// cycle it is taken and produces zero to three result transactions: a peak pair
// at a point boundary, a max-abs value at a chunk boundary, and a flush pair on
// a final sample. One sample is accepted per cycle while m_ready is high and each
// causes at most one result; the result stage emits one result per cycle while
// m_ready is high, until all results of a sample are taken. Data passes the
// state update and then scaling multiplier registers. The configuration port
// is always ready; the user must write it only while idle; no check enforces it.
`include "waveform_peak_envelope_top_defines.svh"

module waveform_peak_envelope_top #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [wpe_pkg::CFG_BITS-1:0]      cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [SAMPLE_BITS-1:0]     s_sample,
    input  logic                              s_is_final,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_kind,
    output logic [wpe_pkg::PEAK_BITS-1:0]     m_upper_peak,
    output logic [wpe_pkg::PEAK_BITS-1:0]     m_lower_peak,
    output logic [wpe_pkg::NORM_BITS-1:0]     m_norm_value,
    output logic                              m_last
);
    import wpe_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int PW = SB + SCALE_BITS;
    localparam int NW = (SB > NORM_BITS) ? SB : NORM_BITS;

    logic [SPP_BITS-1:0]   samples_per_point_reg;
    logic [CHUNK_BITS-1:0] chunk_size_reg;
    logic [SCALE_BITS-1:0] peak_scale_reg;

    logic signed [SB-1:0]  running_max_reg, running_max_next;
    logic signed [SB-1:0]  running_min_reg, running_min_next;
    logic [SPP_BITS-1:0]   point_count_reg, point_count_next;
    logic [SB-1:0]         chunk_max_abs_reg, chunk_max_abs_next;
    logic [CHUNK_BITS-1:0] chunk_count_reg, chunk_count_next;

    logic                  s1_valid_reg, s1_valid_next;
    logic [NSLOT-1:0]      s1_mask_reg, s1_mask_next;
    logic [SB-1:0]         s1_max_reg, s1_max_next;
    logic [SB-1:0]         s1_negmin_reg, s1_negmin_next;
    logic [NORM_BITS-1:0]  s1_norm_reg, s1_norm_next;

    logic [NSLOT-1:0]      s2_mask_reg, s2_mask_next;
    logic [PEAK_BITS-1:0]  s2_upper_reg, s2_upper_next;
    logic [PEAK_BITS-1:0]  s2_lower_reg, s2_lower_next;
    logic [NORM_BITS-1:0]  s2_norm_reg, s2_norm_next;
    logic                  s2_flush_zero_reg, s2_flush_zero_next;

    logic                  in_fire;
    logic                  out_fire;
    logic                  s2_free;
    logic [SB-1:0]         sample_u;
    logic [SB-1:0]         mag;
    logic [SB-1:0]         abs_max_upd;
    logic signed [SB-1:0]  max_upd;
    logic signed [SB-1:0]  min_upd;
    logic [SPP_BITS-1:0]   pc_inc;
    logic                  boundary;
    logic                  chunk_hit;
    logic [NW-1:0]         norm_ext;
    logic [PW-1:0]         prod_up;
    logic [PW-1:0]         prod_lo;
    logic [NSLOT-1:0]      first_bit;
    logic [NSLOT-1:0]      s2_mask_m1;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            samples_per_point_reg <= SPP_RESET;
            chunk_size_reg        <= CHUNK_RESET;
            peak_scale_reg        <= SCALE_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_SAMPLES_PER_POINT: samples_per_point_reg <= cfg_data;
                CFG_CHUNK_SIZE:        chunk_size_reg <= cfg_data[CHUNK_BITS-1:0];
                CFG_PEAK_SCALE:        peak_scale_reg <= cfg_data[SCALE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign in_fire  = s_valid && s_ready;
    assign out_fire = m_valid && m_ready;

    assign sample_u    = s_sample;
    assign mag         = sample_u[SB-1] ? (~sample_u + {{(SB-1){1'b0}}, 1'b1}) : sample_u;
    assign abs_max_upd = (mag > chunk_max_abs_reg) ? mag : chunk_max_abs_reg;
    assign max_upd     = (s_sample > running_max_reg) ? s_sample : running_max_reg;
    assign min_upd     = (s_sample < running_min_reg) ? s_sample : running_min_reg;
    assign pc_inc      = point_count_reg + {{(SPP_BITS-1){1'b0}}, 1'b1};
    assign boundary    = (pc_inc >= samples_per_point_reg) || (pc_inc == '0);
    assign chunk_hit   = (chunk_count_reg == chunk_size_reg);
    assign norm_ext    = NW'(abs_max_upd);

    always_comb begin
        running_max_next   = running_max_reg;
        running_min_next   = running_min_reg;
        point_count_next   = point_count_reg;
        chunk_max_abs_next = chunk_max_abs_reg;
        chunk_count_next   = chunk_count_reg;
        if (in_fire) begin
            running_max_next   = (boundary || s_is_final) ? '0 : max_upd;
            running_min_next   = (boundary || s_is_final) ? '0 : min_upd;
            point_count_next   = (boundary || s_is_final) ? '0 : pc_inc;
            chunk_max_abs_next = (chunk_hit || s_is_final) ? '0 : abs_max_upd;
            if (s_is_final) begin
                chunk_count_next = '0;
            end else if (chunk_hit) begin
                chunk_count_next = {{(CHUNK_BITS-1){1'b0}}, 1'b1};
            end else begin
                chunk_count_next = chunk_count_reg + {{(CHUNK_BITS-1){1'b0}}, 1'b1};
            end
        end
    end

    assign s2_mask_m1 = s2_mask_reg - {{(NSLOT-1){1'b0}}, 1'b1};
    assign first_bit  = s2_mask_reg & ~s2_mask_m1;
    assign s2_free    = (s2_mask_reg == '0) || (m_ready && (s2_mask_reg == first_bit));
    assign s_ready    = !s1_valid_reg || s2_free;

    always_comb begin
        s1_valid_next  = s1_valid_reg;
        s1_mask_next   = s1_mask_reg;
        s1_max_next    = s1_max_reg;
        s1_negmin_next = s1_negmin_reg;
        s1_norm_next   = s1_norm_reg;
        if (in_fire) begin
            s1_mask_next[SLOT_PAIR]  = boundary;
            s1_mask_next[SLOT_NORM]  = chunk_hit;
            s1_mask_next[SLOT_FLUSH] = s_is_final;
            s1_valid_next  = boundary || chunk_hit || s_is_final;
            s1_max_next    = max_upd;
            s1_negmin_next = ~min_upd + {{(SB-1){1'b0}}, 1'b1};
            s1_norm_next   = norm_ext[NORM_BITS-1:0];
        end else if (s2_free) begin
            s1_valid_next = 1'b0;
        end
    end

    assign prod_up = PW'(s1_max_reg) * PW'(peak_scale_reg);
    assign prod_lo = PW'(s1_negmin_reg) * PW'(peak_scale_reg);

    always_comb begin
        s2_mask_next       = s2_mask_reg;
        s2_upper_next      = s2_upper_reg;
        s2_lower_next      = s2_lower_reg;
        s2_norm_next       = s2_norm_reg;
        s2_flush_zero_next = s2_flush_zero_reg;
        if (s1_valid_reg && s2_free) begin
            s2_mask_next       = s1_mask_reg;
            s2_upper_next      = prod_up[SB+PEAK_BITS-2:SB-1];
            s2_lower_next      = prod_lo[SB+PEAK_BITS-2:SB-1];
            s2_norm_next       = s1_norm_reg;
            s2_flush_zero_next = s1_mask_reg[SLOT_PAIR];
        end else if (out_fire) begin
            s2_mask_next = s2_mask_reg & ~first_bit;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_max_reg   <= '0;
            running_min_reg   <= '0;
            point_count_reg   <= '0;
            chunk_max_abs_reg <= '0;
            chunk_count_reg   <= '0;
            s1_valid_reg      <= 1'b0;
            s2_mask_reg       <= '0;
        end else begin
            running_max_reg   <= running_max_next;
            running_min_reg   <= running_min_next;
            point_count_reg   <= point_count_next;
            chunk_max_abs_reg <= chunk_max_abs_next;
            chunk_count_reg   <= chunk_count_next;
            s1_valid_reg      <= s1_valid_next;
            s2_mask_reg       <= s2_mask_next;
        end
    end

    always_ff @(posedge aclk) begin
        s1_mask_reg       <= s1_mask_next;
        s1_max_reg        <= s1_max_next;
        s1_negmin_reg     <= s1_negmin_next;
        s1_norm_reg       <= s1_norm_next;
        s2_upper_reg      <= s2_upper_next;
        s2_lower_reg      <= s2_lower_next;
        s2_norm_reg       <= s2_norm_next;
        s2_flush_zero_reg <= s2_flush_zero_next;
    end

    always_comb begin
        m_valid      = (s2_mask_reg != '0);
        m_last       = (s2_mask_reg == first_bit);
        m_kind       = KIND_PAIR;
        m_upper_peak = '0;
        m_lower_peak = '0;
        m_norm_value = '0;
        if (first_bit[SLOT_PAIR]) begin
            m_upper_peak = s2_upper_reg;
            m_lower_peak = s2_lower_reg;
        end else if (first_bit[SLOT_NORM]) begin
            m_kind       = KIND_NORM;
            m_norm_value = s2_norm_reg;
        end else if (first_bit[SLOT_FLUSH] && !s2_flush_zero_reg) begin
            m_upper_peak = s2_upper_reg;
            m_lower_peak = s2_lower_reg;
        end
    end

    `WPE_ASSERT_NEXT(a_final_clears_state, in_fire && s_is_final,
        point_count_reg == '0 && chunk_count_reg == '0 &&
        running_max_reg == '0 && running_min_reg == '0)
    `WPE_ASSERT_NOW(a_peak_signs, 1'b1,
        !running_max_reg[SB-1] && (running_min_reg[SB-1] || running_min_reg == '0))
    `WPE_ASSERT_NOW(a_stage_not_empty, s1_valid_reg, s1_mask_reg != '0)
    `WPE_ASSERT_NEXT(a_stall_holds_stage, s1_valid_reg && !s_ready,
        s1_valid_reg && $stable(s1_mask_reg) && $stable(s1_max_reg))

endmodule

### verif/testbench.sv
// Self-checking testbench for the waveform peak envelope decimator.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import wpe_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD = 120;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 410;

    typedef struct {
        kind_t       kind;
        logic [7:0]  upper;
        logic [7:0]  lower;
        logic [15:0] norm;
        logic        last;
    } envelope_word_t;

    class envelope_tracker;
        logic [20:0]    spp_reg;
        logic [15:0]    chunk_reg;
        logic [7:0]     scale_reg;
        int             peak_hi;
        int             peak_lo;
        logic [20:0]    point_cnt;
        int             chunk_peak;
        logic [15:0]    chunk_cnt;
        envelope_word_t pending_words[$];
        int             mismatches;

        function new();
            spp_reg = SPP_RESET;
            chunk_reg = CHUNK_RESET;
            scale_reg = SCALE_RESET;
            mismatches = 0;
            clear();
        endfunction

        function void clear();
            peak_hi = 0;
            peak_lo = 0;
            point_cnt = '0;
            chunk_peak = 0;
            chunk_cnt = '0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [20:0] data);
            case (idx)
                CFG_SAMPLES_PER_POINT: spp_reg = data;
                CFG_CHUNK_SIZE:        chunk_reg = data[15:0];
                CFG_PEAK_SCALE:        scale_reg = data[7:0];
                default: ;
            endcase
        endfunction

        function envelope_word_t pair_word();
            envelope_word_t w;
            w.kind = KIND_PAIR;
            w.upper = 8'((peak_hi * int'(scale_reg)) >> 15);
            w.lower = 8'(((0 - peak_lo) * int'(scale_reg)) >> 15);
            w.norm = '0;
            w.last = 1'b0;
            peak_hi = 0;
            peak_lo = 0;
            return w;
        endfunction

        function void take_sample(logic signed [15:0] smp, logic fin);
            envelope_word_t fresh[$];
            envelope_word_t w;
            int s;
            int mag;
            s = smp;
            mag = (s < 0) ? -s : s;
            if (mag > chunk_peak) chunk_peak = mag;
            if (s > peak_hi) peak_hi = s;
            if (s < peak_lo) peak_lo = s;
            point_cnt = point_cnt + 21'd1;
            if (point_cnt >= spp_reg || point_cnt == '0) begin
                fresh.push_back(pair_word());
                point_cnt = '0;
            end
            if (chunk_cnt == chunk_reg) begin
                w.kind = KIND_NORM;
                w.upper = '0;
                w.lower = '0;
                w.norm = chunk_peak[15:0];
                w.last = 1'b0;
                fresh.push_back(w);
                chunk_peak = 0;
                chunk_cnt = '0;
            end
            chunk_cnt = chunk_cnt + 16'd1;
            if (fin) begin
                fresh.push_back(pair_word());
                clear();
            end
            if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
            foreach (fresh[i]) pending_words.push_back(fresh[i]);
        endfunction

        function void note_fault(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%s", msg);
        endfunction

        function void match_result(logic kind, logic [7:0] up, logic [7:0] lo,
                                   logic [15:0] norm, logic last);
            envelope_word_t w;
            if (pending_words.size() == 0) begin
                note_fault($sformatf({"Unexpected result: kind %0d upper %0d",
                                      " lower %0d norm %0d last %0d"},
                                     kind, up, lo, norm, last));
            end else begin
                w = pending_words.pop_front();
                if (kind !== w.kind || up !== w.upper || lo !== w.lower ||
                    norm !== w.norm || last !== w.last) begin
                    note_fault($sformatf({"Result mismatch: expected kind %0d upper %0d lower %0d",
                                          " norm %0d last %0d, got kind %0d upper %0d lower %0d",
                                          " norm %0d last %0d"},
                                         w.kind, w.upper, w.lower, w.norm, w.last,
                                         kind, up, lo, norm, last));
                end
            end
        endfunction

        function int outstanding();
            return pending_words.size();
        endfunction
    endclass

    logic              aclk;
    logic              aresetn = 1'b0;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [1:0]        cfg_index = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic signed [15:0] s_sample = '0;
    logic              s_is_final = 1'b0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_kind;
    logic [PEAK_BITS-1:0] m_upper_peak;
    logic [PEAK_BITS-1:0] m_lower_peak;
    logic [NORM_BITS-1:0] m_norm_value;
    logic              m_last;

    envelope_tracker tracker = new();
    int idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int sink_wait = 0;
    int cycle_cnt = 0;

    waveform_peak_envelope_top #(
        .SAMPLE_BITS(16)
    ) u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .s_is_final   (s_is_final),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_upper_peak (m_upper_peak),
        .m_lower_peak (m_lower_peak),
        .m_norm_value (m_norm_value),
        .m_last       (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("waveform_peak_envelope_top test failed");
        $finish;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_seen != hold_req) begin
            hold_seen = hold_req;
            sink_wait = LONG_HOLD - 1;
            m_ready <= 1'b0;
        end else if (sink_wait > 0) begin
            sink_wait--;
            m_ready <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            sink_wait = $urandom_range(1, 11) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            tracker.match_result(m_kind, m_upper_peak, m_lower_peak, m_norm_value, m_last);
        end
    end

    task automatic cfg_write(input logic [1:0] idx, input logic [20:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        tracker.write_reg(idx, data);
    endtask

    task automatic cfg_close();
        cfg_valid <= 1'b0;
    endtask

    task automatic push_sample(input logic signed [15:0] smp, input logic fin);
        int gap;
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 11);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_sample <= smp;
        s_is_final <= fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tracker.take_sample(smp, fin);
    endtask

    task automatic settle_idle();
        s_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return '0;
            3: return '1;
            4: return 16'($urandom_range(0, 15));
            5: return 16'(0 - $urandom_range(1, 16));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [20:0] pick_spp();
        case ($urandom_range(0, 7))
            0: return 21'd0;
            1: return 21'd1;
            2, 3: return 21'($urandom_range(2, 6));
            4: return 21'($urandom_range(7, 40));
            5: return 21'd1048576;
            6: return 21'h1FFFFF;
            default: return 21'($urandom);
        endcase
    endfunction

    function automatic logic [20:0] pick_chunk();
        logic [15:0] c;
        case ($urandom_range(0, 7))
            0: c = 16'd0;
            1: c = 16'd1;
            2, 3: c = 16'($urandom_range(2, 12));
            4: c = 16'($urandom_range(13, 100));
            5: c = 16'd65535;
            6: c = 16'($urandom);
            default: c = 16'($urandom_range(2, 40));
        endcase
        return {5'($urandom), c};
    endfunction

    function automatic logic [20:0] pick_scale();
        logic [7:0] sc;
        case ($urandom_range(0, 4))
            0: sc = 8'd0;
            1: sc = 8'd1;
            2: sc = 8'd255;
            default: sc = 8'($urandom);
        endcase
        return {13'($urandom), sc};
    endfunction

    initial begin
        int rand_items;
        int phase_no;
        int n_items;
        logic fin;

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(-16'sd1, 1'b0);
        push_sample(16'sd1, 1'b0);
        push_sample(16'sd0, 1'b1);
        push_sample(16'sd0, 1'b1);
        settle_idle();

        cfg_write(CFG_SAMPLES_PER_POINT, 21'd1);
        cfg_write(CFG_CHUNK_SIZE, {5'h1F, 16'd1});
        cfg_write(CFG_PEAK_SCALE, 21'd255);
        cfg_write(CFG_SPARE, 21'h1FFFFF);
        cfg_close();
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh1234, 1'b1);
        settle_idle();

        cfg_write(CFG_SAMPLES_PER_POINT, 21'd0);
        cfg_write(CFG_CHUNK_SIZE, 21'd0);
        cfg_write(CFG_PEAK_SCALE, 21'd0);
        cfg_close();
        push_sample(16'sd100, 1'b0);
        push_sample(-16'sd200, 1'b1);
        settle_idle();

        // A lowered point size takes effect on the very next sample.
        cfg_write(CFG_SAMPLES_PER_POINT, 21'h1FFFFF);
        cfg_write(CFG_CHUNK_SIZE, 21'd65535);
        cfg_write(CFG_PEAK_SCALE, 21'd1);
        cfg_close();
        push_sample(16'sh7FFF, 1'b0);
        push_sample(16'sh8000, 1'b0);
        push_sample(16'sd7, 1'b0);
        settle_idle();
        cfg_write(CFG_SAMPLES_PER_POINT, 21'd2);
        cfg_close();
        push_sample(16'sd5, 1'b0);
        push_sample(-16'sd5, 1'b1);

        rand_items = 0;
        phase_no = 0;
        while (rand_items < RANDOM_ITEMS) begin
            settle_idle();
            case ($urandom_range(0, 2))
                0: idle_pct = 0;
                1: idle_pct = 8;
                default: idle_pct = 25;
            endcase
            if (rand_items >= RANDOM_ITEMS - 60) idle_pct = 0;
            if (phase_no == 2) begin
                // Hold the result side for a long time so the block backs up its input.
                cfg_write(CFG_SAMPLES_PER_POINT, 21'd1);
                cfg_write(CFG_CHUNK_SIZE, 21'd3);
                idle_pct = 0;
                hold_req++;
            end else begin
                if ($urandom_range(0, 3) != 0) cfg_write(CFG_SAMPLES_PER_POINT, pick_spp());
                if ($urandom_range(0, 3) != 0) cfg_write(CFG_CHUNK_SIZE, pick_chunk());
                if ($urandom_range(0, 3) != 0) cfg_write(CFG_PEAK_SCALE, pick_scale());
            end
            cfg_close();
            n_items = $urandom_range(8, 40);
            for (int k = 0; k < n_items; k++) begin
                if (k == n_items / 2 && (phase_no == 3 || $urandom_range(0, 4) == 0)) begin
                    settle_idle();
                end
                fin = ($urandom_range(0, 24) == 0) ||
                      (k == n_items - 1 && $urandom_range(0, 1) == 1);
                push_sample(rand_sample(), fin);
            end
            rand_items += n_items;
            phase_no++;
        end

        settle_idle();
        if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
            $display("waveform_peak_envelope_top test passed");
        end else begin
            $display("waveform_peak_envelope_top test failed");
        end
        $finish;
    end
endmodule
